// ----- rtl/particle_density_flux_deposit_defines.svh -----
// Assertion macros shared by the checker of the particle deposition block.
// Each macro expects a signal named clock in the calling scope; all but PDFD_ASSERT_NXT_ALL also use reset.
`ifndef PARTICLE_DENSITY_FLUX_DEPOSIT_DEFINES_SVH
`define PARTICLE_DENSITY_FLUX_DEPOSIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define PDFD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define PDFD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define PDFD_ASSERT_NXT_ALL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pdfd_pkg.sv -----
// Types and constants of the particle deposition block.
// Used by the front end, the back end and the checker; no dependencies.
`default_nettype none

package pdfd_pkg;

   localparam int IDX_X_W = 9;
   localparam int IDX_W   = 8;
   localparam int WGT_W   = 25;
   localparam int VEL_W   = 32;
   localparam int CELL_W  = 48;
   localparam int DEN_W   = 47;
   localparam int WORD_W  = 4 * CELL_W;

   localparam logic [1:0] OP_DEPOSIT = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_ABSENT = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;
   localparam logic [1:0] STATUS_SAT    = 2'd3;

   localparam logic [1:0] KIND_DEPOSIT = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;
   localparam logic [1:0] KIND_REPORT  = 2'd3;

   typedef struct packed {
      logic [1:0]               kind;
      logic [1:0]               status;
      logic                     xlo;
      logic [IDX_X_W-1:0]       ix0;
      logic [IDX_X_W-1:0]       ix1;
      logic [IDX_W-1:0]         iy0;
      logic [IDX_W-1:0]         iy1;
      logic [IDX_W-1:0]         iz0;
      logic [IDX_W-1:0]         iz1;
      logic [WGT_W-1:0]         wx0;
      logic [WGT_W-1:0]         wx1;
      logic [WGT_W-1:0]         wy0;
      logic [WGT_W-1:0]         wy1;
      logic [WGT_W-1:0]         wz0;
      logic [WGT_W-1:0]         wz1;
      logic signed [VEL_W-1:0]  vx;
      logic signed [VEL_W-1:0]  vy;
      logic signed [VEL_W-1:0]  vz;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/pdfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pdfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/pdfd_fifo.sv -----
// Two-entry queue between the front end and the back end.
// No dependencies.
`default_nettype none

module pdfd_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign full  = count_ff[1];
   assign empty = (count_ff == 2'd0);

endmodule

`default_nettype wire

// ----- rtl/pdfd_front.sv -----
// Front end: takes requests, classifies them and builds queue commands.
// Depends on pdfd_pkg.
`default_nettype none

module pdfd_front #(
   parameter int GRID_X    = 16,
   parameter int GRID_Y    = 16,
   parameter int GRID_Z    = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         op,
   input  logic signed [20:0] pos_x,
   input  logic [19:0]        pos_y,
   input  logic [19:0]        pos_z,
   input  logic signed [31:0] vel_x,
   input  logic signed [31:0] vel_y,
   input  logic signed [31:0] vel_z,
   input  logic [4:0]         cell_x,
   input  logic [3:0]         cell_y,
   input  logic [3:0]         cell_z,
   input  logic signed [16:0] ghost_min,
   input  logic               queue_full,
   input  logic               init_busy,
   output logic               push,
   output pdfd_pkg::cmd_type  cmd
);

   localparam logic [31:0]        ONE     = 32'd1 << FRAC_BITS;
   localparam logic [31:0]        FMASK   = ONE - 32'd1;
   localparam logic signed [31:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);

   logic signed [31:0] xs;
   logic signed [31:0] gmin;
   logic [31:0]        ux;
   logic [31:0]        uy;
   logic [31:0]        uz;
   logic [31:0]        ixl;
   logic [31:0]        iyl;
   logic [31:0]        izl;
   logic [31:0]        iyn;
   logic [31:0]        izn;
   logic [31:0]        frx;
   logic [31:0]        fry;
   logic [31:0]        frz;
   logic [31:0]        wghost;
   logic               yz_out;

   assign req_tready = !queue_full && !init_busy;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      xs     = 32'(pos_x);
      gmin   = 32'(ghost_min);
      ux     = xs;
      uy     = 32'(pos_y);
      uz     = 32'(pos_z);
      ixl    = ux >> FRAC_BITS;
      iyl    = uy >> FRAC_BITS;
      izl    = uz >> FRAC_BITS;
      iyn    = iyl + 32'd1;
      izn    = izl + 32'd1;
      frx    = ux & FMASK;
      fry    = uy & FMASK;
      frz    = uz & FMASK;
      wghost = xs + ONE;
      yz_out = (iyl >= 32'(GRID_Y)) || (izl >= 32'(GRID_Z));

      cmd      = '0;
      cmd.vx   = vel_x;
      cmd.vy   = vel_y;
      cmd.vz   = vel_z;
      cmd.iy0  = iyl[7:0];
      cmd.iy1  = (iyn == 32'(GRID_Y)) ? '0 : iyn[7:0];
      cmd.iz0  = izl[7:0];
      cmd.iz1  = (izn == 32'(GRID_Z)) ? '0 : izn[7:0];
      cmd.wy1  = fry[pdfd_pkg::WGT_W-1:0];
      cmd.wy0  = pdfd_pkg::WGT_W'(ONE - fry);
      cmd.wz1  = frz[pdfd_pkg::WGT_W-1:0];
      cmd.wz0  = pdfd_pkg::WGT_W'(ONE - frz);

      case (op)
         pdfd_pkg::OP_DEPOSIT: begin
            if (!pos_x[20]) begin
               if ((ixl >= 32'(GRID_X)) || yz_out) begin
                  cmd.kind   = pdfd_pkg::KIND_REPORT;
                  cmd.status = pdfd_pkg::STATUS_RANGE;
               end else begin
                  cmd.kind = pdfd_pkg::KIND_DEPOSIT;
                  cmd.ix0  = ixl[8:0];
                  cmd.ix1  = 9'(ixl + 32'd1);
                  cmd.wx1  = frx[pdfd_pkg::WGT_W-1:0];
                  cmd.wx0  = pdfd_pkg::WGT_W'(ONE - frx);
               end
            end else if ((xs >= gmin) && (xs >= NEG_ONE)) begin
               // ghost particle: only the upper x corners, all in plane zero
               if (yz_out) begin
                  cmd.kind   = pdfd_pkg::KIND_REPORT;
                  cmd.status = pdfd_pkg::STATUS_RANGE;
               end else begin
                  cmd.kind = pdfd_pkg::KIND_DEPOSIT;
                  cmd.xlo  = 1'b1;
                  cmd.wx1  = wghost[pdfd_pkg::WGT_W-1:0];
               end
            end else begin
               cmd.kind   = pdfd_pkg::KIND_REPORT;
               cmd.status = pdfd_pkg::STATUS_ABSENT;
            end
         end
         pdfd_pkg::OP_READ: begin
            if ((32'(cell_x) > 32'(GRID_X)) || (32'(cell_y) >= 32'(GRID_Y)) ||
                (32'(cell_z) >= 32'(GRID_Z))) begin
               cmd.kind   = pdfd_pkg::KIND_REPORT;
               cmd.status = pdfd_pkg::STATUS_RANGE;
            end else begin
               cmd.kind = pdfd_pkg::KIND_READ;
               cmd.ix0  = 9'(cell_x);
               cmd.iy0  = 8'(cell_y);
               cmd.iz0  = 8'(cell_z);
            end
         end
         pdfd_pkg::OP_CLEAR: begin
            cmd.kind = pdfd_pkg::KIND_CLEAR;
         end
         default: begin
            cmd.kind   = pdfd_pkg::KIND_REPORT;
            cmd.status = pdfd_pkg::STATUS_RANGE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/pdfd_back.sv -----
// Back end: walks the corners of a deposit through weight, multiply and
// read-modify-write steps, serves reads and clears, and holds the response.
// Depends on pdfd_pkg; drives the grid RAM.
`default_nettype none

module pdfd_back #(
   parameter int GRID_X    = 16,
   parameter int GRID_Y    = 16,
   parameter int GRID_Z    = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       queue_empty,
   input  pdfd_pkg::cmd_type                          queue_head,
   output logic                                       pop,
   output logic                                       init_busy,
   output logic                                       ram_wr_en,
   output logic [$clog2((GRID_X+1)*GRID_Y*GRID_Z)-1:0] ram_wr_addr,
   output logic [pdfd_pkg::WORD_W-1:0]                ram_wr_data,
   output logic [$clog2((GRID_X+1)*GRID_Y*GRID_Z)-1:0] ram_rd_addr,
   input  logic [pdfd_pkg::WORD_W-1:0]                ram_rd_data,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [191:0]                               rsp_tdata,
   output logic [1:0]                                 rsp_tuser
);

   localparam int CELLS = (GRID_X + 1) * GRID_Y * GRID_Z;
   localparam int AW    = $clog2(CELLS);
   localparam int WW    = pdfd_pkg::WGT_W;
   localparam int CW    = pdfd_pkg::CELL_W;

   localparam logic [AW-1:0]          LAST_ADDR = AW'(CELLS - 1);
   localparam logic [2*WW-1:0]        HALF_W    = (2*WW)'(1) << (FRAC_BITS - 1);
   localparam logic signed [57:0]     HALF_P    = 58'sd1 <<< (FRAC_BITS - 1);
   localparam logic [48:0]            DEN_MAX   = (49'd1 << 47) - 49'd1;
   localparam logic signed [59:0]     FLX_HI    = (60'sd1 <<< 47) - 60'sd1;
   localparam logic signed [59:0]     FLX_LO    = -(60'sd1 <<< 47);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_W1    = 4'd2;
   localparam logic [3:0] S_W2    = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_RND   = 4'd5;
   localparam logic [3:0] S_ADD   = 4'd6;
   localparam logic [3:0] S_RADR  = 4'd7;
   localparam logic [3:0] S_RWAIT = 4'd8;
   localparam logic [3:0] S_CLR   = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   function automatic logic [CW:0] flux_add(logic signed [CW-1:0] old,
                                            logic signed [57:0] inc);
      logic signed [59:0] s;
      logic [CW:0]        r;
      begin
         s = 60'(old) + 60'(inc);
         if (s > FLX_HI) begin
            r = {1'b1, FLX_HI[CW-1:0]};
         end else if (s < FLX_LO) begin
            r = {1'b1, FLX_LO[CW-1:0]};
         end else begin
            r = {1'b0, s[CW-1:0]};
         end
         return r;
      end
   endfunction

   logic [3:0]           state_ff;
   logic [3:0]           state_in;
   pdfd_pkg::cmd_type    cmd_ff;
   pdfd_pkg::cmd_type    cmd_in;
   logic [2:0]           corner_ff;
   logic [2:0]           corner_in;
   logic [AW-1:0]        addr_ff;
   logic [AW-1:0]        addr_in;
   logic [AW-1:0]        clr_ff;
   logic [AW-1:0]        clr_in;
   logic [WW-1:0]        pair_ff;
   logic [WW-1:0]        pair_in;
   logic [WW-1:0]        w_ff;
   logic [WW-1:0]        w_in;
   logic signed [57:0]   px_ff;
   logic signed [57:0]   px_in;
   logic signed [57:0]   py_ff;
   logic signed [57:0]   py_in;
   logic signed [57:0]   pz_ff;
   logic signed [57:0]   pz_in;
   logic signed [57:0]   fx_ff;
   logic signed [57:0]   fx_in;
   logic signed [57:0]   fy_ff;
   logic signed [57:0]   fy_in;
   logic signed [57:0]   fz_ff;
   logic signed [57:0]   fz_in;
   logic                 sat_ff;
   logic                 sat_in;
   logic                 rsp_tvalid_ff;
   logic                 rsp_tvalid_in;
   logic [191:0]         rsp_tdata_ff;
   logic [191:0]         rsp_tdata_in;
   logic [1:0]           rsp_tuser_ff;
   logic [1:0]           rsp_tuser_in;

   logic [WW-1:0]        wa;
   logic [WW-1:0]        wb;
   logic [WW-1:0]        wc;
   logic [8:0]           ixs;
   logic [7:0]           iys;
   logic [7:0]           izs;
   logic [31:0]          corner_addr;
   logic [2*WW-1:0]      prod_a;
   logic [2*WW-1:0]      prod_b;
   logic signed [57:0]   mul_x;
   logic signed [57:0]   mul_y;
   logic signed [57:0]   mul_z;
   logic [48:0]          den_sum;
   logic [CW-1:0]        den_new;
   logic                 den_sat;
   logic [CW:0]          fx_new;
   logic [CW:0]          fy_new;
   logic [CW:0]          fz_new;
   logic                 clearing;
   logic [1:0]           res_status;

   always_comb begin
      wa  = corner_ff[2] ? cmd_ff.wx1 : cmd_ff.wx0;
      wb  = corner_ff[1] ? cmd_ff.wy1 : cmd_ff.wy0;
      wc  = corner_ff[0] ? cmd_ff.wz1 : cmd_ff.wz0;
      ixs = corner_ff[2] ? cmd_ff.ix1 : cmd_ff.ix0;
      iys = corner_ff[1] ? cmd_ff.iy1 : cmd_ff.iy0;
      izs = corner_ff[0] ? cmd_ff.iz1 : cmd_ff.iz0;
      corner_addr = (32'(ixs) * 32'(GRID_Y) + 32'(iys)) * 32'(GRID_Z) + 32'(izs);
   end

   assign prod_a = wa * wb;
   assign prod_b = pair_ff * wc;
   assign mul_x  = $signed({1'b0, w_ff}) * cmd_ff.vx;
   assign mul_y  = $signed({1'b0, w_ff}) * cmd_ff.vy;
   assign mul_z  = $signed({1'b0, w_ff}) * cmd_ff.vz;

   always_comb begin
      den_sum = {1'b0, ram_rd_data[CW-1:0]} + 49'(w_ff);
      den_sat = den_sum > DEN_MAX;
      den_new = den_sat ? DEN_MAX[CW-1:0] : den_sum[CW-1:0];
      fx_new  = flux_add(ram_rd_data[2*CW-1:CW], fx_ff);
      fy_new  = flux_add(ram_rd_data[3*CW-1:2*CW], fy_ff);
      fz_new  = flux_add(ram_rd_data[4*CW-1:3*CW], fz_ff);
   end

   assign clearing    = (state_ff == S_INIT) || (state_ff == S_CLR);
   assign ram_wr_en   = clearing || (state_ff == S_ADD);
   assign ram_wr_addr = clearing ? clr_ff : addr_ff;
   assign ram_wr_data = clearing ? '0 :
                        {fz_new[CW-1:0], fy_new[CW-1:0], fx_new[CW-1:0], den_new};
   assign ram_rd_addr = addr_ff;
   assign init_busy   = (state_ff == S_INIT);
   assign pop         = (state_ff == S_IDLE) && !queue_empty;

   always_comb begin
      case (cmd_ff.kind)
         pdfd_pkg::KIND_DEPOSIT: res_status = sat_ff ? pdfd_pkg::STATUS_SAT
                                                     : pdfd_pkg::STATUS_DONE;
         pdfd_pkg::KIND_REPORT:  res_status = cmd_ff.status;
         default:                res_status = pdfd_pkg::STATUS_DONE;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      corner_in     = corner_ff;
      addr_in       = addr_ff;
      clr_in        = clr_ff;
      pair_in       = pair_ff;
      w_in          = w_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pz_in         = pz_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      fz_in         = fz_ff;
      sat_in        = sat_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      case (state_ff)
         S_INIT, S_CLR: begin
            if (clr_ff == LAST_ADDR) begin
               clr_in   = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_OUT;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (!queue_empty) begin
               cmd_in = queue_head;
               sat_in = 1'b0;
               case (queue_head.kind)
                  pdfd_pkg::KIND_DEPOSIT: begin
                     corner_in = {queue_head.xlo, 2'b00};
                     state_in  = S_W1;
                  end
                  pdfd_pkg::KIND_READ: begin
                     corner_in = 3'd0;
                     state_in  = S_RADR;
                  end
                  pdfd_pkg::KIND_CLEAR: state_in = S_CLR;
                  default:              state_in = S_OUT;
               endcase
            end
         end
         S_W1: begin
            pair_in  = WW'((prod_a + HALF_W) >> FRAC_BITS);
            addr_in  = corner_addr[AW-1:0];
            state_in = S_W2;
         end
         S_W2: begin
            w_in     = WW'((prod_b + HALF_W) >> FRAC_BITS);
            state_in = S_MUL;
         end
         S_MUL: begin
            px_in    = mul_x;
            py_in    = mul_y;
            pz_in    = mul_z;
            state_in = S_RND;
         end
         S_RND: begin
            // round half up, for negative products as well
            fx_in    = (px_ff + HALF_P) >>> FRAC_BITS;
            fy_in    = (py_ff + HALF_P) >>> FRAC_BITS;
            fz_in    = (pz_ff + HALF_P) >>> FRAC_BITS;
            state_in = S_ADD;
         end
         S_ADD: begin
            sat_in = sat_ff || den_sat || fx_new[CW] || fy_new[CW] || fz_new[CW];
            if (corner_ff == 3'd7) begin
               state_in = S_OUT;
            end else begin
               corner_in = corner_ff + 3'd1;
               state_in  = S_W1;
            end
         end
         S_RADR: begin
            addr_in  = corner_addr[AW-1:0];
            state_in = S_RWAIT;
         end
         S_RWAIT: state_in = S_OUT;
         S_OUT: begin
            // hold until the response register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_status;
               if (cmd_ff.kind == pdfd_pkg::KIND_READ) begin
                  rsp_tdata_in = {1'b0, ram_rd_data[4*CW-1:CW],
                                  ram_rd_data[pdfd_pkg::DEN_W-1:0]};
               end else begin
                  rsp_tdata_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         clr_ff        <= '0;
         corner_ff     <= 3'd0;
         sat_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         corner_ff     <= corner_in;
         sat_ff        <= sat_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      pair_ff      <= pair_in;
      w_ff         <= w_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pz_ff        <= pz_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      fz_ff        <= fz_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ----- rtl/particle_density_flux_deposit.sv -----
// Cloud-in-cell deposition of particles onto density and x/y/z flux grids.
//
// req channel: one request per item; req_tuser carries the operation (deposit,
// read one cell, clear all grids). rsp channel: exactly one response per
// request, in order; rsp_tuser carries the status code.
// csr port: ghost_min at byte address 0, written with psel/penable/pwrite.
//
// Flow: a request enters a two-entry queue; the back end then takes it.
// A deposit walks its corners one at a time, each through two weight
// multiplies, a velocity multiply, rounding and a read-modify-write on the
// grid RAM; a full particle has eight corners, a ghost particle four. A read
// sets the cell address, waits for the registered RAM data and then responds;
// a status-only request goes straight to the response. A clear sweeps the RAM
// one cell per cycle, (GRID_X+1)*GRID_Y*GRID_Z cells (4352 at default sizes).
// Reset starts the same sweep; req_tready stays low until it ends.
// The response sits in an output register; while rsp_tready is low the back
// end holds, and the queue keeps taking requests until it is full.
`default_nettype none

module particle_density_flux_deposit #(
   parameter int GRID_X    = 16,
   parameter int GRID_Y    = 16,
   parameter int GRID_Z    = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x[20:0] pos_y[40:21] pos_z[60:41] vel_x[92:61] vel_y[124:93]
   // vel_z[156:125] cell_x[161:157] cell_y[165:162] cell_z[169:166]
   input  logic [175:0] req_tdata,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // density[46:0] flux_x[94:47] flux_y[142:95] flux_z[190:143]
   output logic [191:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int CELLS = (GRID_X + 1) * GRID_Y * GRID_Z;
   localparam int AW    = $clog2(CELLS);
   localparam int CMD_W = $bits(pdfd_pkg::cmd_type);

   logic signed [16:0]            ghost_min_ff;
   logic signed [16:0]            ghost_min_in;
   logic                          queue_full;
   logic                          queue_empty;
   logic                          push;
   logic                          pop;
   logic                          init_busy;
   pdfd_pkg::cmd_type             front_cmd;
   pdfd_pkg::cmd_type             queue_head;
   logic [CMD_W-1:0]              queue_head_bits;
   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [pdfd_pkg::WORD_W-1:0]   ram_wr_data;
   logic [AW-1:0]                 ram_rd_addr;
   logic [pdfd_pkg::WORD_W-1:0]   ram_rd_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(ghost_min_ff);

   always_comb begin
      ghost_min_in = ghost_min_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]) begin
         ghost_min_in = csr_pwdata[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ghost_min_ff <= -17'sd65536;
      end else begin
         ghost_min_ff <= ghost_min_in;
      end
   end

   pdfd_front #(
      .GRID_X    (GRID_X),
      .GRID_Y    (GRID_Y),
      .GRID_Z    (GRID_Z),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (req_tuser),
      .pos_x      (req_tdata[20:0]),
      .pos_y      (req_tdata[40:21]),
      .pos_z      (req_tdata[60:41]),
      .vel_x      (req_tdata[92:61]),
      .vel_y      (req_tdata[124:93]),
      .vel_z      (req_tdata[156:125]),
      .cell_x     (req_tdata[161:157]),
      .cell_y     (req_tdata[165:162]),
      .cell_z     (req_tdata[169:166]),
      .ghost_min  (ghost_min_ff),
      .queue_full (queue_full),
      .init_busy  (init_busy),
      .push       (push),
      .cmd        (front_cmd)
   );

   pdfd_fifo #(
      .WIDTH (CMD_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .pop       (pop),
      .head      (queue_head_bits),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign queue_head = queue_head_bits;

   pdfd_back #(
      .GRID_X    (GRID_X),
      .GRID_Y    (GRID_Y),
      .GRID_Z    (GRID_Z),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .pop         (pop),
      .init_busy   (init_busy),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   pdfd_ram #(
      .WIDTH (pdfd_pkg::WORD_W),
      .DEPTH (CELLS)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ----- rtl/pdfd_checker.sv -----
// Port-level checks of the particle deposition block, bound to the top level.
// Depends on pdfd_pkg and the assertion macros header.
`default_nettype none
`include "particle_density_flux_deposit_defines.svh"

module pdfd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [191:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   `PDFD_ASSERT_NXT(rsp_hold_a, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped")
   `PDFD_ASSERT_NXT(rsp_stable_a, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")
   `PDFD_ASSERT_IMP(rsp_zero_a, rsp_tvalid && (rsp_tuser != pdfd_pkg::STATUS_DONE), rsp_tdata == '0, "sums not zero")
   `PDFD_ASSERT_NXT_ALL(init_block_a, reset, !req_tready, "request taken during clearing pass")

endmodule

bind particle_density_flux_deposit pdfd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ----- tb/sv/particle_density_flux_deposit_tb.sv -----
// Testbench for the particle density and flux deposition block.
// Uses pdfd_pkg and the RTL top level. A scoreboard class predicts every response.
`timescale 1ns / 1ps

module particle_density_flux_deposit_tb;

   localparam int NX = 16, NY = 16, NZ = 16;
   localparam int CELLS = (NX + 1) * NY * NZ;
   localparam longint ONE = 64'd65536, HALF = 64'd32768;
   localparam longint DMAX = (64'sd1 <<< 47) - 1;
   localparam longint FMAX = (64'sd1 <<< 47) - 1;
   localparam longint FMIN = -(64'sd1 <<< 47);
   localparam int LIMIT = 1000000;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam logic [2:0] ADDR_GHOST_MIN = 3'd0;

   typedef struct {
      logic [46:0] density;
      logic [47:0] flux_x, flux_y, flux_z;
      logic [1:0]  status;
   } cell_sums_type;

   class deposit_scoreboard_type;
      longint den[CELLS], fx[CELLS], fy[CELLS], fz[CELLS];
      longint ghost_min;
      cell_sums_type pending_q[$];
      int fails;
      bit sat;

      function new();
         ghost_min = -65536;
         fails = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (den[i]) begin
            den[i] = 0; fx[i] = 0; fy[i] = 0; fz[i] = 0;
         end
      endfunction

      function longint clamp(longint s, longint lo, longint hi);
         if (s > hi) begin
            sat = 1; return hi;
         end
         if (s < lo) begin
            sat = 1; return lo;
         end
         return s;
      endfunction

      function logic [1:0] deposit(logic [175:0] d);
         longint x, y, z, vx, vy, vz, w, pr;
         longint ix[2], iy[2], iz[2], wx[2], wy[2], wz[2];
         int a0, idx;
         x = longint'($signed(d[20:0]));
         y = longint'(d[40:21]);
         z = longint'(d[60:41]);
         vx = longint'($signed(d[92:61]));
         vy = longint'($signed(d[124:93]));
         vz = longint'($signed(d[156:125]));
         if (x >= 0) begin
            if ((x >> 16) >= NX || (y >> 16) >= NY || (z >> 16) >= NZ)
               return pdfd_pkg::STATUS_RANGE;
            ix[0] = x >> 16; ix[1] = ix[0] + 1;
            wx[1] = x & (ONE - 1); wx[0] = ONE - wx[1];
            a0 = 0;
         end else if (x >= ghost_min && x >= -ONE) begin
            if ((y >> 16) >= NY || (z >> 16) >= NZ) return pdfd_pkg::STATUS_RANGE;
            ix[0] = 0; ix[1] = 0;
            wx[0] = 0; wx[1] = x + ONE;
            a0 = 1;
         end else begin
            return pdfd_pkg::STATUS_ABSENT;
         end
         iy[0] = y >> 16; iy[1] = (iy[0] + 1 == NY) ? 0 : iy[0] + 1;
         iz[0] = z >> 16; iz[1] = (iz[0] + 1 == NZ) ? 0 : iz[0] + 1;
         wy[1] = y & (ONE - 1); wy[0] = ONE - wy[1];
         wz[1] = z & (ONE - 1); wz[0] = ONE - wz[1];
         sat = 0;
         for (int a = a0; a < 2; a++)
            for (int b = 0; b < 2; b++)
               for (int c = 0; c < 2; c++) begin
                  pr = (wx[a] * wy[b] + HALF) >> 16;
                  w = (pr * wz[c] + HALF) >> 16;
                  idx = int'((ix[a] * NY + iy[b]) * NZ + iz[c]);
                  den[idx] = clamp(den[idx] + w, 0, DMAX);
                  fx[idx] = clamp(fx[idx] + ((w * vx + HALF) >>> 16), FMIN, FMAX);
                  fy[idx] = clamp(fy[idx] + ((w * vy + HALF) >>> 16), FMIN, FMAX);
                  fz[idx] = clamp(fz[idx] + ((w * vz + HALF) >>> 16), FMIN, FMAX);
               end
         return sat ? pdfd_pkg::STATUS_SAT : pdfd_pkg::STATUS_DONE;
      endfunction

      function void note_request(logic [1:0] op, logic [175:0] d);
         cell_sums_type e;
         int cx, cy, cz, idx;
         e = '{47'd0, 48'd0, 48'd0, 48'd0, pdfd_pkg::STATUS_DONE};
         case (op)
            pdfd_pkg::OP_DEPOSIT: e.status = deposit(d);
            pdfd_pkg::OP_READ: begin
               cx = d[161:157]; cy = d[165:162]; cz = d[169:166];
               if (cx > NX || cy >= NY || cz >= NZ) begin
                  e.status = pdfd_pkg::STATUS_RANGE;
               end else begin
                  idx = (cx * NY + cy) * NZ + cz;
                  e.density = den[idx][46:0];
                  e.flux_x = fx[idx][47:0];
                  e.flux_y = fy[idx][47:0];
                  e.flux_z = fz[idx][47:0];
               end
            end
            pdfd_pkg::OP_CLEAR: wipe();
            default: e.status = pdfd_pkg::STATUS_RANGE;
         endcase
         pending_q.push_back(e);
      endfunction

      function void check_response(logic [191:0] d, logic [1:0] st);
         cell_sums_type e;
         if (pending_q.size() == 0) begin
            $error("response with no request outstanding");
            fails++;
            return;
         end
         e = pending_q.pop_front();
         if (d[46:0] !== e.density) begin
            $error("density expected %h actual %h", e.density, d[46:0]); fails++;
         end
         if (d[94:47] !== e.flux_x) begin
            $error("flux_x expected %h actual %h", e.flux_x, d[94:47]); fails++;
         end
         if (d[142:95] !== e.flux_y) begin
            $error("flux_y expected %h actual %h", e.flux_y, d[142:95]); fails++;
         end
         if (d[190:143] !== e.flux_z) begin
            $error("flux_z expected %h actual %h", e.flux_z, d[190:143]); fails++;
         end
         if (st !== e.status) begin
            $error("status expected %0d actual %0d", e.status, st); fails++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [175:0] req_tdata = '0;
   logic [1:0] req_tuser = pdfd_pkg::OP_DEPOSIT;
   logic rsp_tvalid, rsp_tready = 0;
   logic [191:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = ADDR_GHOST_MIN;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   logic csr_pready;

   particle_density_flux_deposit uut (.*);

   deposit_scoreboard_type sums = new();
   bit idling = 0;
   int hold_off = 0;
   int cycles = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("particle_density_flux_deposit test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sums.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sums.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // receiver: long hold when asked, otherwise random stall bursts while idling is set
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   function automatic logic [175:0] pack_req(logic [20:0] px, logic [19:0] py,
                                             logic [19:0] pz, logic [31:0] vx,
                                             logic [31:0] vy, logic [31:0] vz,
                                             logic [4:0] cx, logic [3:0] cy,
                                             logic [3:0] cz);
      return {6'd0, cz, cy, cx, vz, vy, vx, pz, py, px};
   endfunction

   task automatic send(logic [1:0] op, logic [175:0] d);
      int gap;
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic deposit_at(logic [20:0] px, logic [19:0] py, logic [19:0] pz,
                             logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      send(pdfd_pkg::OP_DEPOSIT, pack_req(px, py, pz, vx, vy, vz, 0, 0, 0));
   endtask

   task automatic read_cell(logic [4:0] cx, logic [3:0] cy, logic [3:0] cz);
      send(pdfd_pkg::OP_READ, pack_req($urandom, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, cx, cy, cz));
   endtask

   task automatic drain();
      // drop valid right away so the last request is not offered twice
      req_tvalid <= 0;
      @(posedge clock);
      while (sums.pending_q.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_ghost_min(logic [16:0] val);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= ADDR_GHOST_MIN;
      csr_pwdata <= {{15{val[16]}}, val};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      sums.ghost_min = longint'($signed(val));
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic random_items(int count);
      int pick;
      logic [20:0] px;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 199);
         if (pick < 130) begin
            // keep most particles near a corner region so reads see sums
            if ($urandom_range(0, 3) == 0) px = $urandom;
            else px = 21'($signed($urandom_range(0, 4 * 65536)) - 65536);
            deposit_at(px, ($urandom_range(0, 1) ? 20'hE0000 + $urandom_range(0, 20'h1FFFF)
                                                : $urandom),
                       ($urandom_range(0, 1) ? 20'hE0000 + $urandom_range(0, 20'h1FFFF)
                                             : $urandom),
                       $urandom, $urandom, $urandom);
         end else if (pick < 190) begin
            if ($urandom_range(0, 4) == 0) read_cell($urandom, $urandom, $urandom);
            else read_cell($urandom_range(0, 4), $urandom_range(0, 1) ? 0 : 14 + $urandom_range(0, 1),
                           $urandom_range(0, 1) ? 0 : 14 + $urandom_range(0, 1));
         end else if (pick < 198) begin
            send(OP_UNKNOWN, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
         end else begin
            send(pdfd_pkg::OP_CLEAR, {$urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom});
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      // directed: extremes, ghost and absent particles, wraps, reads, an unknown op, clear
      write_ghost_min(17'h10000);
      deposit_at(21'd0, 20'd0, 20'd0, 32'h7FFFFFFF, 32'h80000000, 32'd1);
      deposit_at(21'h0FFFFF, 20'hFFFFF, 20'hFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
      deposit_at(21'h1FFFFF, 20'h0FFFF, 20'h18000, 32'h00010000, 32'hFFFF0000, 32'd0);
      deposit_at(21'h1F0000, 20'h08000, 20'h08000, 32'h12345678, 32'h9ABCDEF0, 32'h0);
      deposit_at(21'h1EFFFF, 20'h0, 20'h0, 32'h1, 32'h1, 32'h1);
      deposit_at(21'h100000, 20'h0, 20'h0, 32'h1, 32'h1, 32'h1);
      read_cell(5'd0, 4'd0, 4'd0);
      read_cell(5'd16, 4'd15, 4'd15);
      read_cell(5'd16, 4'd0, 4'd0);
      read_cell(5'd15, 4'd15, 4'd0);
      read_cell(5'd0, 4'd0, 4'd1);
      read_cell(5'd17, 4'd0, 4'd0);
      read_cell(5'd31, 4'd15, 4'd15);
      send(OP_UNKNOWN, '1);
      send(pdfd_pkg::OP_CLEAR, '0);
      read_cell(5'd0, 4'd0, 4'd0);
      read_cell(5'd16, 4'd15, 4'd15);
      drain();
      write_ghost_min(17'h00000);
      deposit_at(21'h1FFFFF, 20'h0, 20'h0, 32'h1, 32'h1, 32'h1);
      deposit_at(21'h000001, 20'h1, 20'h1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      read_cell(5'd0, 4'd0, 4'd0);
      drain();
      // random with idling and one long receiver hold
      idling = 1;
      write_ghost_min(17'($urandom_range(0, 65536)) ^ 17'h1FFFF);
      fork
         random_items(500);
         begin
            repeat (200) @(posedge clock);
            hold_off = 400;
         end
      join
      drain();
      write_ghost_min(17'h00000);
      random_items(500);
      drain();
      // last part runs without idling
      idling = 0;
      write_ghost_min(17'h10000);
      random_items(450);
      drain();
      if (sums.fails == 0 && sums.pending_q.size() == 0) begin
         $display("particle_density_flux_deposit test passed");
      end else begin
         $display("particle_density_flux_deposit test failed");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pdfd_pkg.sv
rtl/pdfd_ram.sv
rtl/pdfd_fifo.sv
rtl/pdfd_front.sv
rtl/pdfd_back.sv
rtl/particle_density_flux_deposit.sv
rtl/pdfd_checker.sv
tb/sv/particle_density_flux_deposit_tb.sv
